// File: rtl/adaptive_line_average_deinterlace_top_defines.svh
// assertion macros for the adaptive line average deinterlacer
// used by the top level, expects clk and rst in scope
`ifndef ADAPTIVE_LINE_AVERAGE_DEINTERLACE_TOP_DEFINES_SVH
`define ADAPTIVE_LINE_AVERAGE_DEINTERLACE_TOP_DEFINES_SVH

// checked outside reset
`define ALAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ALAD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/alad_pkg.sv
// shared types, codes and helpers for the adaptive line average deinterlacer
// no dependencies
`default_nettype none

package alad_pkg;

  localparam int PixW    = 32;
  localparam int ByteW   = 8;
  localparam int NBytes  = 4;
  localparam int NRegs   = 4;
  localparam int CfgIdxW = 8;
  localparam int CfgDatW = 8;

  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_UYVY   = 2'd1;
  localparam logic [1:0] MODE_YUYV   = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_COLOUR_START = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_COLOUR_BYTES = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_METRIC_MODE  = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_METRIC_BYTE  = 8'd3;

  typedef logic [PixW-1:0]  pix_t;
  typedef logic [ByteW-1:0] byte_t;

  typedef struct packed {
    logic       colour_start;
    logic [2:0] colour_bytes;
    logic [1:0] metric_mode;
    logic [1:0] metric_byte;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{colour_start: 1'b0, colour_bytes: 3'd3,
                                 metric_mode: MODE_SINGLE, metric_byte: 2'd1};

  function automatic byte_t byte_of(input pix_t w, input logic [1:0] k);
    byte_of = w[k*ByteW +: ByteW];
  endfunction

  // one bit per byte position inside the colour range
  function automatic logic [NBytes-1:0] colour_mask(input cfg_t c);
    logic [3:0] lo;
    logic [3:0] hi;
    logic [NBytes-1:0] m;
    lo = {3'd0, c.colour_start};
    hi = lo + {1'b0, c.colour_bytes};
    for (int k = 0; k < NBytes; k++) begin
      m[k] = (4'(k) >= lo) && (4'(k) < hi);
    end
    colour_mask = m;
  endfunction

endpackage

`default_nettype wire

// File: rtl/alad_metric.sv
// per-row metric lane: one 8-bit activity value from pixels a and c
// depends on alad_pkg
`default_nettype none

module alad_metric (
  input  wire alad_pkg::cfg_t  cfg,
  input  wire alad_pkg::pix_t  pa,
  input  wire alad_pkg::pix_t  pc,
  output alad_pkg::byte_t      metric
);

  logic [9:0] sum4;
  logic [8:0] sum2;

  always_comb begin
    sum4 = '0;
    sum2 = '0;
    metric = '0;
    unique case (cfg.metric_mode)
      alad_pkg::MODE_UYVY: begin
        sum4 = 10'(alad_pkg::byte_of(pa, 2'd1)) + 10'(alad_pkg::byte_of(pa, 2'd3))
             + 10'(alad_pkg::byte_of(pc, 2'd1)) + 10'(alad_pkg::byte_of(pc, 2'd3));
        metric = sum4[9:2];
      end
      alad_pkg::MODE_YUYV: begin
        sum4 = 10'(alad_pkg::byte_of(pa, 2'd0)) + 10'(alad_pkg::byte_of(pa, 2'd2))
             + 10'(alad_pkg::byte_of(pc, 2'd0)) + 10'(alad_pkg::byte_of(pc, 2'd2));
        metric = sum4[9:2];
      end
      default: begin
        sum2 = 9'(alad_pkg::byte_of(pa, cfg.metric_byte))
             + 9'(alad_pkg::byte_of(pc, cfg.metric_byte));
        metric = sum2[8:1];
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/alad_blend.sv
// per-pixel blend lane: lower row byte select between row +1 and the average
// depends on alad_pkg
`default_nettype none

module alad_blend (
  input  wire alad_pkg::pix_t             row0,
  input  wire alad_pkg::pix_t             row1,
  input  wire alad_pkg::pix_t             row2,
  input  wire [alad_pkg::NBytes-1:0]      mask,
  input  wire                             mix,
  output alad_pkg::pix_t                  lower
);

  logic [alad_pkg::ByteW:0] sum [alad_pkg::NBytes];

  always_comb begin
    for (int k = 0; k < alad_pkg::NBytes; k++) begin
      sum[k] = {1'b0, row0[k*alad_pkg::ByteW +: alad_pkg::ByteW]}
             + {1'b0, row2[k*alad_pkg::ByteW +: alad_pkg::ByteW]};
      if (mix && mask[k]) begin
        lower[k*alad_pkg::ByteW +: alad_pkg::ByteW] = sum[k][alad_pkg::ByteW:1];
      end else begin
        lower[k*alad_pkg::ByteW +: alad_pkg::ByteW] =
          row1[k*alad_pkg::ByteW +: alad_pkg::ByteW];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/adaptive_line_average_deinterlace_top.sv
// pipeline: input transaction registered in stage 1, then in the output register
// throughput: one three-pixel group per cycle while the output is not stalled, four
// metric lanes and three blend lanes in parallel, merged by one compare stage
// reset: synchronous, clears both stage valids and loads the register defaults
// depends on alad_pkg, alad_metric, alad_blend and the defines header
`default_nettype none
`include "adaptive_line_average_deinterlace_top_defines.svh"

module adaptive_line_average_deinterlace_top (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  // above_pair, cur_a, cur_b, cur_c, next_a, next_b, next_c, below_a, below_b, below_c
  input  wire  [351:0]                     s_tdata,
  output logic                             m_tvalid,
  input  wire                              m_tready,
  // upper_a, upper_b, upper_c, lower_a, lower_b, lower_c
  output logic [191:0]                     m_tdata,
  // interpolated
  output logic [0:0]                       m_tuser,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [alad_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire  [alad_pkg::CfgDatW-1:0]     cfg_data
);

  alad_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= alad_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        alad_pkg::REG_COLOUR_START: cfg.colour_start <= cfg_data[0];
        alad_pkg::REG_COLOUR_BYTES: cfg.colour_bytes <= cfg_data[2:0];
        alad_pkg::REG_METRIC_MODE:  cfg.metric_mode  <= cfg_data[1:0];
        alad_pkg::REG_METRIC_BYTE:  cfg.metric_byte  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // stage 1: metric lanes
  alad_pkg::pix_t  pa [4];
  alad_pkg::pix_t  pc [4];
  alad_pkg::byte_t metric [4];

  assign pa[0] = s_tdata[31:0];
  assign pc[0] = s_tdata[63:32];
  assign pa[1] = s_tdata[95:64];
  assign pc[1] = s_tdata[159:128];
  assign pa[2] = s_tdata[191:160];
  assign pc[2] = s_tdata[255:224];
  assign pa[3] = s_tdata[287:256];
  assign pc[3] = s_tdata[351:320];

  for (genvar r = 0; r < 4; r++) begin : g_metric
    alad_metric u_metric (
      .cfg    (cfg),
      .pa     (pa[r]),
      .pc     (pc[r]),
      .metric (metric[r])
    );
  end

  logic            en1;
  logic            en2;
  logic            s1_valid;
  alad_pkg::byte_t s1_metric [4];
  logic [95:0]     s1_cur;
  logic [95:0]     s1_next;
  logic [95:0]     s1_below;

  assign en2      = !m_tvalid || m_tready;
  assign en1      = !s1_valid || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && s_tvalid) begin
      s1_metric <= metric;
      s1_cur    <= s_tdata[159:64];
      s1_next   <= s_tdata[255:160];
      s1_below  <= s_tdata[351:256];
    end
  end

  // stage 2: merge metrics into one decision, then blend lanes
  logic [7:0] ad_an, ad_cb, ad_ab, ad_cn;
  logic [8:0] d1, d2;
  logic       mix;
  logic [alad_pkg::NBytes-1:0] mask;
  alad_pkg::pix_t lower [3];

  function automatic logic [7:0] abs_diff(input logic [7:0] x, input logic [7:0] y);
    abs_diff = (x > y) ? x - y : y - x;
  endfunction

  assign ad_an = abs_diff(s1_metric[0], s1_metric[2]);
  assign ad_cb = abs_diff(s1_metric[1], s1_metric[3]);
  assign ad_ab = abs_diff(s1_metric[0], s1_metric[3]);
  assign ad_cn = abs_diff(s1_metric[1], s1_metric[2]);
  assign d1    = {1'b0, ad_an} + {1'b0, ad_cb};
  assign d2    = {1'b0, ad_ab} + {1'b0, ad_cn};
  assign mix   = d1 < d2;
  assign mask  = alad_pkg::colour_mask(cfg);

  for (genvar p = 0; p < 3; p++) begin : g_blend
    alad_blend u_blend (
      .row0  (s1_cur[p*32 +: 32]),
      .row1  (s1_next[p*32 +: 32]),
      .row2  (s1_below[p*32 +: 32]),
      .mask  (mask),
      .mix   (mix),
      .lower (lower[p])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en2) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid) begin
      m_tdata <= {lower[2], lower[1], lower[0], s1_cur};
      m_tuser <= mix;
    end
  end

  `ALAD_ASSERT(a_no_drop, (s1_valid && en2) |=> m_tvalid, "stage 1 transaction lost")
  `ALAD_ASSERT(a_upper_copy, (s1_valid && en2) |=> (m_tdata[95:0] == $past(s1_cur)),
    "upper row differs from row 0")
  `ALAD_ASSERT(a_ready_when_empty, !s1_valid |-> s_tready, "input stalled with empty stage")
  `ALAD_ASSERT_ALWAYS(a_reset_clear, rst |=> (!m_tvalid && !s1_valid),
    "valids not cleared by reset")

endmodule

`default_nettype wire
